// ===== hdl/fvcw_pkg.sv =====
// Shared constants, types and the color wheel table of the flow color coder.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package fvcw_pkg;

	// Input and gain widths.
	localparam int FLOW_WIDTH = 16;
	localparam int GAIN_WIDTH = 16;
	localparam int SCALED_WIDTH = FLOW_WIDTH + GAIN_WIDTH + 1;
	localparam int MAG_WIDTH = FLOW_WIDTH + GAIN_WIDTH;
	localparam logic [GAIN_WIDTH-1:0] GAIN_RESET = 16'd256;

	// Color wheel segments.
	localparam int SEG_RY = 15;
	localparam int SEG_YG = 6;
	localparam int SEG_GC = 4;
	localparam int SEG_CB = 11;
	localparam int SEG_BM = 13;
	localparam int SEG_MR = 6;
	localparam int WHEEL_SIZE = SEG_RY + SEG_YG + SEG_GC + SEG_CB + SEG_BM + SEG_MR;
	localparam int FULL = 255;

	// CORDIC geometry.
	localparam int CORDIC_STEPS = 24;
	localparam int NORM_MSB = 45;
	localparam int CX_WIDTH = 50;
	localparam int CZ_WIDTH = 34;
	localparam int CORDIC_LAT = CORDIC_STEPS + 4;

	// Square root geometry.
	localparam int ROOT_WIDTH = 17;
	localparam int SQ_WIDTH = 2 * ROOT_WIDTH;
	localparam int REM_WIDTH = ROOT_WIDTH + 2;
	localparam int ISQRT_LAT = ROOT_WIDTH + 2;
	localparam int ISQRT_PAD = CORDIC_LAT - ISQRT_LAT;

	localparam int COLOR_LAT = 3;
	localparam int LAT_TOTAL = 2 + CORDIC_LAT + COLOR_LAT;

	// Binary angle constants (2^32 is one turn).
	localparam logic [31:0] HALF_TURN = 32'h8000_0000;
	localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
	localparam logic [31:0] THREE_QUARTER = 32'hC000_0000;
	localparam logic [29:0] PHI_MAX = 30'h3FFF_FFFF;

	localparam logic [29:0] ATAN_TURN [CORDIC_STEPS] = '{
		30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756,
		30'd42667331, 30'd21354465, 30'd10679838, 30'd5340245,
		30'd2670163, 30'd1335087, 30'd667544, 30'd333772,
		30'd166886, 30'd83443, 30'd41722, 30'd20861,
		30'd10430, 30'd5215, 30'd2608, 30'd1304,
		30'd652, 30'd326, 30'd163, 30'd81
	};

	// Magnitudes and signs of one scaled vector.
	typedef struct packed {
		logic [MAG_WIDTH-1:0] ax;
		logic [MAG_WIDTH-1:0] ay;
		logic                 x_neg;
		logic                 y_neg;
		logic                 x_zero;
		logic                 y_zero;
	} vec_t;

	// Sign and axis flags that ride along the CORDIC stages.
	typedef struct packed {
		logic x_neg;
		logic y_neg;
		logic x_zero;
		logic y_zero;
	} quad_t;

	// One wheel entry: red in bits 7:0, green 15:8, blue 23:16.
	typedef logic [WHEEL_SIZE-1:0][23:0] wheel_rom_t;

	function automatic wheel_rom_t build_wheel();
		wheel_rom_t rom;
		int r, g, b, i;
		for (int k = 0; k < WHEEL_SIZE; k++) begin
			if (k < SEG_RY) begin
				i = k; r = FULL; g = FULL * i / SEG_RY; b = 0;
			end else if (k < SEG_RY + SEG_YG) begin
				i = k - SEG_RY; r = FULL - FULL * i / SEG_YG; g = FULL; b = 0;
			end else if (k < SEG_RY + SEG_YG + SEG_GC) begin
				i = k - SEG_RY - SEG_YG; r = 0; g = FULL; b = FULL * i / SEG_GC;
			end else if (k < SEG_RY + SEG_YG + SEG_GC + SEG_CB) begin
				i = k - SEG_RY - SEG_YG - SEG_GC; r = 0; g = FULL - FULL * i / SEG_CB; b = FULL;
			end else if (k < WHEEL_SIZE - SEG_MR) begin
				i = k - (WHEEL_SIZE - SEG_MR - SEG_BM); r = FULL * i / SEG_BM; g = 0; b = FULL;
			end else begin
				i = (k - (WHEEL_SIZE - SEG_MR)) % SEG_MR; r = FULL; g = 0;
				b = FULL - FULL * i / SEG_MR;
			end
			rom[k] = {8'(b), 8'(g), 8'(r)};
		end
		return rom;
	endfunction

	localparam wheel_rom_t WHEEL_ROM = build_wheel();

endpackage
`default_nettype wire

// ===== hdl/fvcw_cordic.sv =====
// Angle path: normalize, 24 pipelined vectoring CORDIC stages, quadrant fold,
// and wheel position (entry index and Q0.16 fraction). Depends on fvcw_pkg.
`timescale 1ns / 1ps
`default_nettype none
module fvcw_cordic (
	input  wire logic          clk,
	input  wire logic          en,
	input  wire fvcw_pkg::vec_t vin,
	output logic [5:0]         k0,
	output logic [15:0]        frac
);
	import fvcw_pkg::*;

	logic [MAG_WIDTH-1:0]      ax_a, ay_a;
	logic [5:0]                sh_a;
	quad_t                     fl_a;
	logic [MAG_WIDTH-1:0]      mx;
	logic [4:0]                msb;
	logic signed [CX_WIDTH-1:0] cx_s [0:CORDIC_STEPS];
	logic signed [CX_WIDTH-1:0] cy_s [0:CORDIC_STEPS];
	logic signed [CZ_WIDTH-1:0] cz_s [0:CORDIC_STEPS];
	quad_t                     fl_s [0:CORDIC_STEPS];
	logic [29:0]               phi;
	logic [31:0]               theta;
	logic [31:0]               theta_q;
	logic [37:0]               pos;

	// Leading one of the larger magnitude.
	always_comb begin
		mx = (vin.ax > vin.ay) ? vin.ax : vin.ay;
		msb = '0;
		for (int i = 0; i < MAG_WIDTH; i++) begin
			if (mx[i]) msb = 5'(i);
		end
	end

	// Stage A: shift amount that puts the leading one at bit 45.
	always_ff @(posedge clk) begin
		if (en) begin
			ax_a <= vin.ax;
			ay_a <= vin.ay;
			sh_a <= 6'(NORM_MSB) - {1'b0, msb};
			fl_a <= '{x_neg: vin.x_neg, y_neg: vin.y_neg,
				x_zero: vin.x_zero, y_zero: vin.y_zero};
		end
	end

	// Stage B: normalized start vector.
	always_ff @(posedge clk) begin
		if (en) begin
			cx_s[0] <= $signed(CX_WIDTH'(ax_a) << sh_a);
			cy_s[0] <= $signed(CX_WIDTH'(ay_a) << sh_a);
			cz_s[0] <= '0;
			fl_s[0] <= fl_a;
		end
	end

	// One micro-rotation per stage.
	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
		always_ff @(posedge clk) begin
			if (en) begin
				if (cy_s[i] >= 0) begin
					cx_s[i+1] <= cx_s[i] + (cy_s[i] >>> i);
					cy_s[i+1] <= cy_s[i] - (cx_s[i] >>> i);
					cz_s[i+1] <= cz_s[i] + $signed({4'b0, ATAN_TURN[i]});
				end else begin
					cx_s[i+1] <= cx_s[i] - (cy_s[i] >>> i);
					cy_s[i+1] <= cy_s[i] + (cx_s[i] >>> i);
					cz_s[i+1] <= cz_s[i] - $signed({4'b0, ATAN_TURN[i]});
				end
				fl_s[i+1] <= fl_s[i];
			end
		end
	end

	// Clamp the first-quadrant angle and fold it into the full turn.
	always_comb begin
		if (cz_s[CORDIC_STEPS] < $signed(CZ_WIDTH'(1)))
			phi = 30'd1;
		else if (cz_s[CORDIC_STEPS] > $signed({4'b0, PHI_MAX}))
			phi = PHI_MAX;
		else
			phi = cz_s[CORDIC_STEPS][29:0];
		priority if (fl_s[CORDIC_STEPS].y_zero)
			theta = fl_s[CORDIC_STEPS].x_neg ? HALF_TURN : 32'd0;
		else if (fl_s[CORDIC_STEPS].x_zero)
			theta = fl_s[CORDIC_STEPS].y_neg ? THREE_QUARTER : QUARTER_TURN;
		else if (!fl_s[CORDIC_STEPS].x_neg && !fl_s[CORDIC_STEPS].y_neg)
			theta = {2'b0, phi};
		else if (fl_s[CORDIC_STEPS].x_neg && !fl_s[CORDIC_STEPS].y_neg)
			theta = HALF_TURN - {2'b0, phi};
		else if (fl_s[CORDIC_STEPS].x_neg)
			theta = HALF_TURN + {2'b0, phi};
		else
			theta = 32'd0 - {2'b0, phi};
	end

	always_ff @(posedge clk) begin
		if (en) theta_q <= theta;
	end

	// Wheel position theta * 54 by shift and add.
	assign pos = (38'(theta_q) << 5) + (38'(theta_q) << 4) + (38'(theta_q) << 2)
		+ (38'(theta_q) << 1);

	always_ff @(posedge clk) begin
		if (en) begin
			k0   <= pos[37:32];
			frac <= pos[31:16];
		end
	end

endmodule
`default_nettype wire

// ===== hdl/fvcw_isqrt.sv =====
// Radius path: squares, unit circle test, and a bit-per-stage integer
// square root, delayed to line up with the angle path. Depends on fvcw_pkg.
`timescale 1ns / 1ps
`default_nettype none
module fvcw_isqrt (
	input  wire logic                     clk,
	input  wire logic                     en,
	input  wire fvcw_pkg::vec_t           vin,
	output logic [fvcw_pkg::ROOT_WIDTH-1:0] radius,
	output logic                          in_circle
);
	import fvcw_pkg::*;

	logic [SQ_WIDTH-1:0]   sqa_q1, sqb_q1;
	logic                  small_q1;
	logic [SQ_WIDTH:0]     sum;
	logic [SQ_WIDTH-1:0]   sv_s [0:ROOT_WIDTH];
	logic [REM_WIDTH-1:0]  rem_s [0:ROOT_WIDTH];
	logic [ROOT_WIDTH-1:0] root_s [0:ROOT_WIDTH];
	logic                  in_s [0:ROOT_WIDTH];
	logic [ROOT_WIDTH-1:0] rpad_s [0:ISQRT_PAD];
	logic                  ipad_s [0:ISQRT_PAD];

	// Squares, only meaningful when both magnitudes are at most one.
	always_ff @(posedge clk) begin
		if (en) begin
			small_q1 <= (vin.ax <= 32'h0001_0000) && (vin.ay <= 32'h0001_0000);
			sqa_q1   <= vin.ax[ROOT_WIDTH-1:0] * vin.ax[ROOT_WIDTH-1:0];
			sqb_q1   <= vin.ay[ROOT_WIDTH-1:0] * vin.ay[ROOT_WIDTH-1:0];
		end
	end

	assign sum = {1'b0, sqa_q1} + {1'b0, sqb_q1};

	always_ff @(posedge clk) begin
		if (en) begin
			sv_s[0]   <= sum[SQ_WIDTH-1:0];
			in_s[0]   <= small_q1 && (sum <= 35'h1_0000_0000);
			rem_s[0]  <= '0;
			root_s[0] <= '0;
		end
	end

	// One root bit per stage, two radicand bits consumed each time.
	for (genvar j = 0; j < ROOT_WIDTH; j++) begin : g_root
		logic [REM_WIDTH+1:0] ex, trial;
		assign ex    = {rem_s[j], sv_s[j][SQ_WIDTH-1:SQ_WIDTH-2]};
		assign trial = {2'b0, root_s[j], 2'b01};
		always_ff @(posedge clk) begin
			if (en) begin
				sv_s[j+1] <= sv_s[j] << 2;
				in_s[j+1] <= in_s[j];
				if (ex >= trial) begin
					rem_s[j+1]  <= REM_WIDTH'(ex - trial);
					root_s[j+1] <= {root_s[j][ROOT_WIDTH-2:0], 1'b1};
				end else begin
					rem_s[j+1]  <= REM_WIDTH'(ex);
					root_s[j+1] <= {root_s[j][ROOT_WIDTH-2:0], 1'b0};
				end
			end
		end
	end

	// Delay line to match the angle path.
	assign rpad_s[0] = root_s[ROOT_WIDTH];
	assign ipad_s[0] = in_s[ROOT_WIDTH];
	for (genvar d = 0; d < ISQRT_PAD; d++) begin : g_pad
		always_ff @(posedge clk) begin
			if (en) begin
				rpad_s[d+1] <= rpad_s[d];
				ipad_s[d+1] <= ipad_s[d];
			end
		end
	end

	assign radius    = rpad_s[ISQRT_PAD];
	assign in_circle = ipad_s[ISQRT_PAD];

endmodule
`default_nettype wire

// ===== hdl/fvcw_color.sv =====
// Color stage: wheel lookup with linear blend, then saturation by radius or
// dimming, giving three bytes in reversed channel order. Depends on fvcw_pkg.
`timescale 1ns / 1ps
`default_nettype none
module fvcw_color (
	input  wire logic                       clk,
	input  wire logic                       en,
	input  wire logic [5:0]                 k0,
	input  wire logic [15:0]                frac,
	input  wire logic [fvcw_pkg::ROOT_WIDTH-1:0] radius,
	input  wire logic                       in_circle,
	output logic [23:0]                     bytes
);
	import fvcw_pkg::*;

	logic [5:0]            k1;
	logic [23:0]           w0, w1;
	logic [16:0]           fa, fb;
	logic [23:0]           c_s1 [3];
	logic [ROOT_WIDTH-1:0] r_s1;
	logic                  in_s1;
	logic [40:0]           prod_s2 [3];
	logic [23:0]           c_s2 [3];
	logic                  in_s2;

	assign k1 = (k0 == 6'(WHEEL_SIZE - 1)) ? 6'd0 : k0 + 6'd1;
	assign w0 = WHEEL_ROM[k0];
	assign w1 = WHEEL_ROM[k1];
	assign fb = {1'b0, frac};
	assign fa = 17'h1_0000 - fb;

	// Blend of adjacent entries, per channel.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int ch = 0; ch < 3; ch++) begin
				c_s1[ch] <= 24'(25'(fa) * 25'(w0[8*ch +: 8])
					+ 25'(fb) * 25'(w1[8*ch +: 8]));
			end
			r_s1  <= radius;
			in_s1 <= in_circle;
		end
	end

	// Radius times the distance to white.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int ch = 0; ch < 3; ch++) begin
				prod_s2[ch] <= 41'(r_s1) * 41'(24'hFF_0000 - c_s1[ch]);
				c_s2[ch]    <= c_s1[ch];
			end
			in_s2 <= in_s1;
		end
	end

	// Final bytes; channel 2 lands in the lowest byte.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int ch = 0; ch < 3; ch++) begin
				if (in_s2)
					bytes[8*(2-ch) +: 8] <= 8'((41'h00FF_0000_0000 - prod_s2[ch]) >> 32);
				else
					bytes[8*(2-ch) +: 8] <= 8'((26'(c_s2[ch]) * 26'd3) >> 18);
			end
		end
	end

endmodule
`default_nettype wire

// ===== hdl/flow_vector_color_wheel_top.sv =====
// Top level of the optical flow color coder: gain register, scaling, the
// angle and radius paths, and the color stage. Depends on fvcw_pkg and all submodules.
//
// Channel    Direction  Width  Contents
// s_axis     in         32     flow_x [15:0], flow_y [31:16]
// m_axis     out        24     byte_first [7:0], byte_second [15:8], byte_third [23:16]
// cfg        in         16     flow_gain
//
// One request per cycle is taken while the output is not stalled; each request
// passes through scaling, normalize, the 24 CORDIC stages, fold and color stages.
// All stages advance together; when the output holds an untaken result the
// whole pipeline stalls and the input is not ready. Reset clears the valid
// bits and sets the gain to 1.0.
`timescale 1ns / 1ps
`default_nettype none
module flow_vector_color_wheel_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [31:0] s_axis_tdata,   // flow_x [15:0], flow_y [31:16]
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [23:0]      m_axis_tdata,   // byte_first, byte_second, byte_third
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [15:0] cfg_data
);
	import fvcw_pkg::*;

	logic [GAIN_WIDTH-1:0]          gain_q;
	logic [LAT_TOTAL-1:0]           vld_q;
	logic                           en;
	logic signed [SCALED_WIDTH-1:0] sx_s1, sy_s1;
	vec_t                           vec_s2;
	logic [5:0]                     k0;
	logic [15:0]                    frac;
	logic [ROOT_WIDTH-1:0]          radius;
	logic                           in_circle;

	assign cfg_ready = 1'b1;

	// Gain register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= GAIN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			gain_q <= cfg_data;
		end
	end

	// Pipeline advances unless the output holds a result nobody took.
	assign en = !vld_q[LAT_TOTAL-1] || m_axis_tready;
	assign s_axis_tready = en;
	assign m_axis_tvalid = vld_q[LAT_TOTAL-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT_TOTAL-2:0], s_axis_tvalid};
		end
	end

	// Scale by the gain.
	always_ff @(posedge clk) begin
		if (en) begin
			sx_s1 <= $signed(s_axis_tdata[FLOW_WIDTH-1:0]) * $signed({1'b0, gain_q});
			sy_s1 <= $signed(s_axis_tdata[2*FLOW_WIDTH-1:FLOW_WIDTH])
				* $signed({1'b0, gain_q});
		end
	end

	// Magnitudes and signs.
	always_ff @(posedge clk) begin
		if (en) begin
			vec_s2.ax     <= MAG_WIDTH'(sx_s1[SCALED_WIDTH-1] ? -sx_s1 : sx_s1);
			vec_s2.ay     <= MAG_WIDTH'(sy_s1[SCALED_WIDTH-1] ? -sy_s1 : sy_s1);
			vec_s2.x_neg  <= sx_s1[SCALED_WIDTH-1];
			vec_s2.y_neg  <= sy_s1[SCALED_WIDTH-1];
			vec_s2.x_zero <= (sx_s1 == '0);
			vec_s2.y_zero <= (sy_s1 == '0);
		end
	end

	fvcw_cordic u_cordic (
		.clk  (clk),
		.en   (en),
		.vin  (vec_s2),
		.k0   (k0),
		.frac (frac)
	);

	fvcw_isqrt u_isqrt (
		.clk       (clk),
		.en        (en),
		.vin       (vec_s2),
		.radius    (radius),
		.in_circle (in_circle)
	);

	fvcw_color u_color (
		.clk       (clk),
		.en        (en),
		.k0        (k0),
		.frac      (frac),
		.radius    (radius),
		.in_circle (in_circle),
		.bytes     (m_axis_tdata)
	);

`ifndef SYNTHESIS
	// A stalled output must hold back the input.
	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
		else $error("input accepted while output stalled");

	// An accepted request enters the first stage.
	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> vld_q[0])
		else $error("accepted request lost at first stage");

	// A request one stage from the end reaches the output on the next advance.
	a_reach_output: assert property (@(posedge clk) disable iff (!arst_n)
		(en && vld_q[LAT_TOTAL-2]) |=> m_axis_tvalid)
		else $error("request lost before output");
`endif

endmodule
`default_nettype wire
